/* sv/tile_pyramid_2x2_downscale_top_macros.svh */
// Assertion macros for the port checker of the 2x2 pyramid downscaler.
// Depends on nothing; included by the port checker.
`ifndef TILE_PYRAMID_2X2_DOWNSCALE_TOP_MACROS_SVH
`define TILE_PYRAMID_2X2_DOWNSCALE_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TPD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TPD_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tpd_pkg.sv */
// Shared types and constants of the 2x2 pyramid downscaler.
// Used by the sequencer, the reduce stage and the top level; depends on nothing.
package tpd_pkg;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINEAR_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_SIDE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES     = 2'd2;

    // Register widths and reset values.
    localparam int SIDE_REG_W = 10;
    localparam int SPP_REG_W  = 4;
    localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 10'd256;
    localparam logic [SPP_REG_W-1:0]  SPP_RESET  = 4'd1;

    // Stream payload widths.
    localparam int VALUE_W     = 32;
    localparam int RES_INDEX_W = 21;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 56;
    localparam int RESULT_W    = 1 + RES_INDEX_W + VALUE_W;

    // Control that travels with an accepted beat into the reduce stage.
    typedef struct packed {
        logic emit;    // beat closes a 2x2 block and gives a result
        logic linear;  // average mode in force for this beat
        logic last;    // last result of the source tile
    } t_s1_ctl;

endpackage

/* sv/tpd_pair_mem.sv */
// Line store of horizontal pair sums: one synchronous port, registered read data.
// Depends on nothing; instantiated by the top level.
module tpd_pair_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int W     = 33
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write and read never fall in the same cycle; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tpd_seq.sv */
// Sequencer: configuration registers, raster counters, even-column hold and line-store access.
// Depends on tpd_pkg; drives tpd_pair_mem and tpd_reduce.
module tpd_seq #(
    parameter int MAX_TILE_SIDE = 512,
    parameter int MAX_SAMPLES   = 8,
    parameter int SAMPLE_BITS   = 32,
    parameter int SW            = 10,
    parameter int CW            = 9,
    parameter int PW            = 4,
    parameter int SIW           = 3,
    parameter int AW            = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                           i_valid,
    input  logic                           i_en,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic [1:0]                     i_quad,
    input  logic                           i_start,
    output logic                           o_mem_we,
    output logic                           o_mem_re,
    output logic [AW-1:0]                  o_mem_addr,
    output logic [SAMPLE_BITS:0]           o_mem_wdata,
    output tpd_pkg::t_s1_ctl               o_ctl,
    output logic [SAMPLE_BITS:0]           o_pair_part,
    output logic [2*SW-1:0]                o_pos,
    output logic [SIW-1:0]                 o_smp,
    output logic [PW-1:0]                  o_spp
);

    localparam int CMPW = (SW > tpd_pkg::SIDE_REG_W) ? SW : tpd_pkg::SIDE_REG_W;
    localparam int CMPP = (PW > tpd_pkg::SPP_REG_W) ? PW : tpd_pkg::SPP_REG_W;
    localparam int FW   = AW + CW + PW;

    // Clamp the side register to 2..MAX_TILE_SIDE and force it even.
    function automatic logic [SW-1:0] clamp_side(input logic [tpd_pkg::SIDE_REG_W-1:0] raw);
        logic [CMPW-1:0] t;
        t = CMPW'(raw);
        if (t < CMPW'(2)) t = CMPW'(2);
        if (t > CMPW'(MAX_TILE_SIDE)) t = CMPW'(MAX_TILE_SIDE);
        t[0] = 1'b0;
        return t[SW-1:0];
    endfunction

    // Clamp the samples-per-pixel register to 1..MAX_SAMPLES.
    function automatic logic [PW-1:0] clamp_spp(input logic [tpd_pkg::SPP_REG_W-1:0] raw);
        logic [CMPP-1:0] t;
        t = CMPP'(raw);
        if (t < CMPP'(1)) t = CMPP'(1);
        if (t > CMPP'(MAX_SAMPLES)) t = CMPP'(MAX_SAMPLES);
        return t[PW-1:0];
    endfunction

    logic                   r_linear;
    logic [SW-1:0]          r_side;
    logic [PW-1:0]          r_spp;
    logic [CW-1:0]          r_col;
    logic [CW-1:0]          r_row;
    logic [SIW-1:0]         r_smp;
    logic [SAMPLE_BITS-1:0] r_held [MAX_SAMPLES];

    logic                   acc;
    logic                   restart;
    logic [CW-1:0]          col;
    logic [CW-1:0]          row;
    logic [SIW-1:0]         smp;
    logic [SAMPLE_BITS-1:0] held;
    logic [SAMPLE_BITS:0]   pair_sum;
    logic [FW-1:0]          addr_full;
    logic [SW-1:0]          half;
    logic [SW-1:0]          ox;
    logic [SW-1:0]          oy;
    logic [PW-1:0]          smp_inc;
    logic [SW-1:0]          col_inc;
    logic [SW-1:0]          row_inc;
    logic [CW-1:0]          n_col;
    logic [CW-1:0]          n_row;
    logic [SIW-1:0]         n_smp;

    assign acc = i_valid && i_en;

    // Configuration writes; clamped values are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear <= 1'b1;
            r_side   <= clamp_side(tpd_pkg::SIDE_RESET);
            r_spp    <= clamp_spp(tpd_pkg::SPP_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpd_pkg::CFG_LINEAR_MODE: r_linear <= i_cfg_wdata[0];
                tpd_pkg::CFG_TILE_SIDE:   r_side   <= clamp_side(i_cfg_wdata);
                tpd_pkg::CFG_SAMPLES:     r_spp    <= clamp_spp(i_cfg_wdata[tpd_pkg::SPP_REG_W-1:0]);
                default: ;
            endcase
        end
    end

    // Current position; a tile start or counters beyond the geometry restart at zero.
    always_comb begin
        restart = i_start || (SW'(r_col) >= r_side) || (SW'(r_row) >= r_side)
                  || (PW'(r_smp) >= r_spp);
        col = restart ? '0 : r_col;
        row = restart ? '0 : r_row;
        smp = restart ? '0 : r_smp;
    end

    // Line-store address, held sample and the pair sum of the even row.
    always_comb begin
        held      = r_held[smp];
        pair_sum  = (SAMPLE_BITS+1)'(held) + (SAMPLE_BITS+1)'(i_sample);
        addr_full = FW'(col[CW-1:1]) * FW'(r_spp) + FW'(smp);
    end

    // Coordinates in the assembled output tile.
    always_comb begin
        half = r_side >> 1;
        ox   = SW'(col[CW-1:1]) + (i_quad[0] ? half : '0);
        oy   = SW'(row[CW-1:1]) + (i_quad[1] ? half : '0);
    end

    assign o_mem_addr  = addr_full[AW-1:0];
    assign o_mem_we    = acc && col[0] && !row[0];
    assign o_mem_re    = acc && col[0] && row[0];
    assign o_mem_wdata = r_linear ? pair_sum : (SAMPLE_BITS+1)'(held);

    assign o_ctl.emit   = acc && col[0] && row[0];
    assign o_ctl.linear = r_linear;
    assign o_ctl.last   = (SW'(row) == r_side - SW'(1)) && (SW'(col) == r_side - SW'(1))
                          && (PW'(smp) == r_spp - PW'(1));
    assign o_pair_part  = pair_sum;
    assign o_pos        = (2*SW)'(oy) * (2*SW)'(r_side) + (2*SW)'(ox);
    assign o_smp        = smp;
    assign o_spp        = r_spp;

    // Raster advance: sample, then column, then row.
    always_comb begin
        smp_inc = PW'(smp) + PW'(1);
        col_inc = SW'(col) + SW'(1);
        row_inc = SW'(row) + SW'(1);
        n_smp = smp_inc[SIW-1:0];
        n_col = col;
        n_row = row;
        if (smp_inc >= r_spp) begin
            n_smp = '0;
            n_col = col_inc[CW-1:0];
            if (col_inc >= r_side) begin
                n_col = '0;
                n_row = row_inc[CW-1:0];
                if (row_inc >= r_side) begin
                    n_row = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_smp <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
            r_smp <= n_smp;
        end
    end

    // Even-column samples wait here for their right neighbor.
    always_ff @(posedge i_clk) begin
        if (acc && !col[0]) begin
            r_held[smp] <= i_sample;
        end
    end

endmodule

/* sv/tpd_reduce.sv */
// Reduce stage: combines the line-store read with the odd-row pair and forms the output index.
// Depends on tpd_pkg; fed by tpd_seq and tpd_pair_mem, feeds tpd_out_buf.
module tpd_reduce #(
    parameter int SAMPLE_BITS = 32,
    parameter int SW          = 10,
    parameter int PW          = 4,
    parameter int SIW         = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  tpd_pkg::t_s1_ctl              i_ctl,
    input  logic [SAMPLE_BITS:0]          i_pair_part,
    input  logic [2*SW-1:0]               i_pos,
    input  logic [SIW-1:0]                i_smp,
    input  logic [PW-1:0]                 i_spp,
    input  logic [SAMPLE_BITS:0]          i_rdata,
    output logic                          o_push,
    output logic [tpd_pkg::RESULT_W-1:0]  o_result
);

    localparam int IXW0 = 2*SW + PW;
    localparam int IXW  = (IXW0 > tpd_pkg::RES_INDEX_W) ? IXW0 : tpd_pkg::RES_INDEX_W;

    logic                 r_emit;
    logic                 r_linear;
    logic                 r_last;
    logic [SAMPLE_BITS:0] r_pair_part;
    logic [2*SW-1:0]      r_pos;
    logic [SIW-1:0]       r_smp;

    logic [SAMPLE_BITS+1:0]        sum;
    logic [SAMPLE_BITS-1:0]        value;
    logic [IXW-1:0]                index_full;

    // Stage register; moves whenever the output side has room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (i_en) begin
            r_emit <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.emit) begin
            r_linear    <= i_ctl.linear;
            r_last      <= i_ctl.last;
            r_pair_part <= i_pair_part;
            r_pos       <= i_pos;
            r_smp       <= i_smp;
        end
    end

    // Average of the four samples, or the stored top-left sample.
    always_comb begin
        sum   = (SAMPLE_BITS+2)'(i_rdata) + (SAMPLE_BITS+2)'(r_pair_part);
        value = r_linear ? sum[SAMPLE_BITS+1:2] : i_rdata[SAMPLE_BITS-1:0];
    end

    assign index_full = IXW'(r_pos) * IXW'(i_spp) + IXW'(r_smp);

    assign o_push   = r_emit && i_en;
    assign o_result = {r_last, index_full[tpd_pkg::RES_INDEX_W-1:0],
                       tpd_pkg::VALUE_W'(value)};

endmodule

/* sv/tpd_out_buf.sv */
// Output register with a skid stage, so the input keeps flowing while a result waits.
// Depends on nothing; instantiated by the top level.
module tpd_out_buf #(
    parameter int W = 54
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_room,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_out_valid;
    logic [W-1:0] r_out_data;
    logic         r_skid_valid;
    logic [W-1:0] r_skid_data;
    logic         out_free;

    assign out_free = !r_out_valid || i_ready;

    // Control: skid first, then a fresh push; a push is only possible while the skid is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (r_skid_valid) begin
                if (out_free) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload follows the same choices.
    always_ff @(posedge i_clk) begin
        priority if (r_skid_valid) begin
            if (out_free) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (out_free) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

/* sv/tile_pyramid_2x2_downscale_top.sv */
// A closing beat is held in the reduce stage register, then in the output register or skid stage.
// Throughput: one beat per cycle while ready; at most one line-store access per beat, on one port.
// o_s_axis_tready falls only while a result sits in the skid stage behind a stalled output.
// Reset: linear mode, tile side 256, one sample per pixel, counters at zero, no result pending.
// The line store and the even-column hold are not cleared; each entry is written before it is read.
module tile_pyramid_2x2_downscale_top #(
    parameter int MAX_TILE_SIDE = 512,
    parameter int MAX_SAMPLES   = 8,
    parameter int SAMPLE_BITS   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [tpd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Sample beats.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [tpd_pkg::VALUE_W-1:0]     i_s_axis_tdata,  // [31:0] sample_value
    input  logic [tpd_pkg::IN_USER_W-1:0]   i_s_axis_tuser,  // [1:0] quadrant, [2] tile_start
    // Result beats.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [tpd_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // [31:0] reduced_value, [52:32] result_index
    output logic                            o_m_axis_tlast   // quarter_last
);

    localparam int SW      = $clog2(MAX_TILE_SIDE + 1);
    localparam int CW      = (MAX_TILE_SIDE > 2) ? $clog2(MAX_TILE_SIDE) : 2;
    localparam int PW      = $clog2(MAX_SAMPLES + 1);
    localparam int SIW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int DEPTH   = (MAX_TILE_SIDE / 2) * MAX_SAMPLES;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                           w_room;
    logic                           w_mem_we;
    logic                           w_mem_re;
    logic [AW-1:0]                  w_mem_addr;
    logic [SAMPLE_BITS:0]           w_mem_wdata;
    logic [SAMPLE_BITS:0]           w_mem_rdata;
    tpd_pkg::t_s1_ctl               w_ctl;
    logic [SAMPLE_BITS:0]           w_pair_part;
    logic [2*SW-1:0]                w_pos;
    logic [SIW-1:0]                 w_smp;
    logic [PW-1:0]                  w_spp;
    logic                           w_push;
    logic [tpd_pkg::RESULT_W-1:0]   w_result;
    logic [tpd_pkg::RESULT_W-1:0]   w_out;

    assign o_s_axis_tready = w_room;

    tpd_seq #(
        .MAX_TILE_SIDE (MAX_TILE_SIDE),
        .MAX_SAMPLES   (MAX_SAMPLES),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .SW            (SW),
        .CW            (CW),
        .PW            (PW),
        .SIW           (SIW),
        .AW            (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_en        (w_room),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_quad      (i_s_axis_tuser[1:0]),
        .i_start     (i_s_axis_tuser[2]),
        .o_mem_we    (w_mem_we),
        .o_mem_re    (w_mem_re),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .o_ctl       (w_ctl),
        .o_pair_part (w_pair_part),
        .o_pos       (w_pos),
        .o_smp       (w_smp),
        .o_spp       (w_spp)
    );

    tpd_pair_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (SAMPLE_BITS + 1)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    tpd_reduce #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SW          (SW),
        .PW          (PW),
        .SIW         (SIW)
    ) u_reduce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_room),
        .i_ctl       (w_ctl),
        .i_pair_part (w_pair_part),
        .i_pos       (w_pos),
        .i_smp       (w_smp),
        .i_spp       (w_spp),
        .i_rdata     (w_mem_rdata),
        .o_push      (w_push),
        .o_result    (w_result)
    );

    tpd_out_buf #(
        .W (tpd_pkg::RESULT_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_room  (w_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out)
    );

    // Result beat: value and index in tdata, last flag on tlast.
    assign o_m_axis_tdata = tpd_pkg::OUT_DATA_W'(w_out[tpd_pkg::RESULT_W-2:0]);
    assign o_m_axis_tlast = w_out[tpd_pkg::RESULT_W-1];

endmodule

/* sv/tpd_port_checker.sv */
// Port-level checks of the 2x2 pyramid downscaler, bound to the top level.
// Depends on tile_pyramid_2x2_downscale_top_macros.svh and tpd_pkg.
`include "tile_pyramid_2x2_downscale_top_macros.svh"

module tpd_port_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [tpd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    // At the edge that follows a sampled reset, nothing is pending and the input is open.
    `TPD_ASSERT_ALL(a_reset_clear, i_clk, (!i_rst_n ##1 1'b1) |-> (!o_m_axis_tvalid && o_s_axis_tready), "state not cleared by reset")

    // The input only closes while a result is already offered.
    `TPD_ASSERT_RST(a_ready_needs_result, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid, "input stalled with no result offered")

    // The input closes only after a result beat was refused.
    `TPD_ASSERT_RST(a_ready_falls_on_stall, i_clk, i_rst_n, $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready), "input stalled without an output stall")

    // A refused result beat stays and holds its payload.
    `TPD_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "result beat changed while stalled")

endmodule

bind tile_pyramid_2x2_downscale_top tpd_port_checker u_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* test/tile_pyramid_2x2_downscale_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the 2x2 pyramid downscaler: streams source tiles, predicts each
// reduced sample in place and compares every result beat. Depends on tpd_pkg and the top level.
module tile_pyramid_2x2_downscale_top_tb;

    localparam int CLK_HALF_NS = 5;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_SIDE = 512;
    localparam int MAX_SPP = 8;
    localparam int LINE_DEPTH = (MAX_SIDE / 2) * MAX_SPP;
    localparam int RANDOM_BEATS = 150;
    localparam int FULL_TILE_LIMIT = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT = 20000;
    localparam longint TIMEOUT_NS = 3_000_000;
    localparam logic [tpd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum logic [1:0] {
        QUAD_TOP_LEFT,
        QUAD_TOP_RIGHT,
        QUAD_BOTTOM_LEFT,
        QUAD_BOTTOM_RIGHT
    } t_quadrant;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HEAVY} t_rx_mode;

    typedef struct {
        logic [31:0] value;
        t_quadrant   quad;
        logic        start;
    } t_sample_beat;

    typedef struct {
        logic [31:0] value;
        logic [20:0] index;
        logic        last;
    } t_reduced;

    // Ports of the block; its inputs are driven to known values from time zero.
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [tpd_pkg::CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic [tpd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata = '0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [tpd_pkg::VALUE_W-1:0]       i_s_axis_tdata = '0;   // [31:0] sample_value
    logic [tpd_pkg::IN_USER_W-1:0]     i_s_axis_tuser = '0;   // [1:0] quadrant, [2] tile_start
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic [tpd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata;        // [31:0] reduced_value, [52:32] result_index
    logic                              o_m_axis_tlast;        // quarter_last

    // Stimulus and expectation stores.
    t_sample_beat source_samples[$];
    t_reduced     reductions_due[$];

    // Mirror of the block's registers and state.
    logic              mirror_linear = 1'b1;
    logic [9:0]        mirror_side = tpd_pkg::SIDE_RESET;
    logic [3:0]        mirror_spp = tpd_pkg::SPP_RESET;
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;
    int unsigned       smp_pos = 0;
    logic [33:0]       line_sums [LINE_DEPTH];
    logic [31:0]       held_even [MAX_SPP];

    // Handshake bookkeeping.
    bit                beat_taken = 1'b0;
    bit                sender_steady = 1'b0;
    int unsigned       burst_left = 0;
    int unsigned       gap_left = 0;
    t_sample_beat      next_beat;
    t_sample_beat      taken_beat;
    t_reduced          want;
    t_rx_mode          rx_mode = RX_FREE;
    int unsigned       rx_tick = 0;
    int unsigned       hold_left = 0;
    int unsigned       holds_requested = 0;
    int unsigned       holds_granted = 0;

    // Run statistics.
    int unsigned       mismatches = 0;
    int unsigned       beats_accepted = 0;
    int unsigned       reductions_checked = 0;
    int unsigned       settings_used = 0;
    int unsigned       random_queued = 0;

    tile_pyramid_2x2_downscale_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Side in use: clamped to 2..MAX_SIDE with the low bit cleared.
    function automatic int unsigned eff_side_of(input logic [9:0] word);
        int unsigned s;
        s = word;
        if (s < 2) s = 2;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s & ~32'd1;
    endfunction

    function automatic int unsigned eff_spp_of(input logic [3:0] word);
        int unsigned n;
        n = word;
        if (n < 1) n = 1;
        if (n > MAX_SPP) n = MAX_SPP;
        return n;
    endfunction

    // Advances the mirrored counters by one sample and queues the reduced sample it closes.
    function automatic void downscale_sample(input t_sample_beat b);
        int unsigned side, spp, col, row, smp, addr, half, ox, oy;
        logic [33:0] total;
        t_reduced r;
        side = eff_side_of(mirror_side);
        spp = eff_spp_of(mirror_spp);
        if (b.start || col_pos >= side || row_pos >= side || smp_pos >= spp) begin
            col_pos = 0;
            row_pos = 0;
            smp_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        smp = smp_pos;
        addr = (col >> 1) * spp + smp;
        if (col[0] == 1'b0) begin
            held_even[smp] = b.value;
        end else if (row[0] == 1'b0) begin
            // Even row: keep the horizontal pair sum, or just the top-left sample.
            line_sums[addr] = mirror_linear ? {2'b00, held_even[smp]} + b.value
                                            : {2'b00, held_even[smp]};
        end else begin
            half = side >> 1;
            ox = (col >> 1) + (b.quad[0] ? half : 0);
            oy = (row >> 1) + (b.quad[1] ? half : 0);
            total = mirror_linear ? line_sums[addr] + held_even[smp] + b.value : line_sums[addr];
            r.value = mirror_linear ? total[33:2] : total[31:0];
            r.index = 21'(spp * (oy * side + ox) + smp);
            r.last = (row == side - 1) && (col == side - 1) && (smp == spp - 1);
            reductions_due.insert(reductions_due.size(), r);
        end
        smp_pos = smp + 1;
        if (smp_pos >= spp) begin
            smp_pos = 0;
            col_pos = col + 1;
            if (col_pos >= side) begin
                col_pos = 0;
                row_pos = row + 1;
                if (row_pos >= side) row_pos = 0;
            end
        end
    endfunction

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_beat(input logic [31:0] value, input t_quadrant quad,
                                      input logic start);
        t_sample_beat b;
        b.value = value;
        b.quad = quad;
        b.start = start;
        source_samples.insert(source_samples.size(), b);
    endfunction

    // One register write; the mirror follows at once since nothing is in flight.
    task automatic write_register(input logic [tpd_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [tpd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= data;
        case (index)
            tpd_pkg::CFG_LINEAR_MODE: mirror_linear = data[0];
            tpd_pkg::CFG_TILE_SIDE:   mirror_side = data;
            tpd_pkg::CFG_SAMPLES:     mirror_spp = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued beat went in and every reduced sample came out, then lets
    // the pipeline settle so that beats without a result have left it too.
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        while ((source_samples.size() != 0 || i_s_axis_tvalid || reductions_due.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            $error("%0d reduced samples still outstanding after %0d cycles",
                   reductions_due.size(), waited);
            mismatches++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one setting and streams tiles under it. Small tiles go whole; large ones are
    // cut after the first row and a few closing columns. Some tiles carry noise: cut short,
    // a stray tile start, quadrant changing per beat, or no tile start so the counters wrap.
    task automatic run_phase(input logic [9:0] linear_word, input logic [9:0] side_word,
                             input logic [9:0] spp_word, input int unsigned target);
        int unsigned side, spp, tile_beats, count, queued;
        bit noisy, with_start;
        t_quadrant quad, beat_quad;
        side = eff_side_of(side_word);
        spp = eff_spp_of(spp_word[3:0]);
        write_register(tpd_pkg::CFG_LINEAR_MODE, linear_word);
        write_register(tpd_pkg::CFG_TILE_SIDE, side_word);
        write_register(tpd_pkg::CFG_SAMPLES, spp_word);
        settings_used++;
        tile_beats = side * side * spp;
        queued = 0;
        while (queued < target) begin
            noisy = ($urandom_range(0, 9) == 0);
            quad = t_quadrant'($urandom_range(0, 3));
            with_start = (queued == 0) || ($urandom_range(0, 9) != 0);
            count = (tile_beats <= FULL_TILE_LIMIT) ? tile_beats
                                                     : side * spp + $urandom_range(2, 32) * spp;
            if (noisy && $urandom_range(0, 1) == 1) count = $urandom_range(1, count);
            for (int unsigned i = 0; i < count; i++) begin
                beat_quad = (noisy && $urandom_range(0, 3) == 0) ?
                            t_quadrant'($urandom_range(0, 3)) : quad;
                push_beat(random_sample(), beat_quad,
                          (i == 0 && with_start) || (noisy && $urandom_range(0, 60) == 0));
            end
            queued += count;
        end
        random_queued += queued;
        drain_results();
    endtask

    // Sender: bursts of random length with random gaps, or back to back when steady.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || beat_taken)) begin
            if (!sender_steady && gap_left != 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (source_samples.size() != 0) begin
                next_beat = source_samples.pop_front();
                i_s_axis_tdata <= next_beat.value;
                i_s_axis_tuser <= {next_beat.start, next_beat.quad};
                i_s_axis_tvalid <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = $urandom_range(1, 6);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: a stall pattern chosen per phase, plus long hold-offs on request.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (holds_granted != holds_requested) begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:    i_m_axis_tready <= 1'b1;
                RX_RANDOM:  i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: begin
                    rx_tick++;
                    i_m_axis_tready <= ((rx_tick % 5) < 3);
                end
                default:    i_m_axis_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Monitor: checks each result beat against the oldest prediction, then predicts from
    // the sample beat taken at this edge.
    always @(posedge i_clk) begin
        beat_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (reductions_due.size() == 0) begin
                $error("result beat with nothing due: value %h index %0d last %b",
                       o_m_axis_tdata[31:0], o_m_axis_tdata[52:32], o_m_axis_tlast);
                mismatches++;
            end else begin
                want = reductions_due.pop_front();
                reductions_checked++;
                if (o_m_axis_tdata[31:0] !== want.value) begin
                    $error("reduced_value: expected %h, got %h", want.value, o_m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[52:32] !== want.index) begin
                    $error("result_index: expected %0d, got %0d", want.index,
                           o_m_axis_tdata[52:32]);
                    mismatches++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("quarter_last: expected %b, got %b", want.last, o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if (beat_taken) begin
            taken_beat.value = i_s_axis_tdata;
            taken_beat.quad = t_quadrant'(i_s_axis_tuser[1:0]);
            taken_beat.start = i_s_axis_tuser[2];
            beats_accepted++;
            downscale_sample(taken_beat);
        end
    end

    initial begin
        logic [9:0] side_word, spp_word, linear_word;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest tile: all-ones block in the last quadrant, then a second tile without
        // a tile start so the counters wrap on their own.
        write_register(tpd_pkg::CFG_LINEAR_MODE, 10'd1);
        write_register(tpd_pkg::CFG_TILE_SIDE, 10'd2);
        write_register(tpd_pkg::CFG_SAMPLES, 10'd1);
        write_register(CFG_UNUSED_INDEX, 10'($urandom_range(0, 1023)));
        settings_used++;
        for (int i = 0; i < 4; i++) push_beat(32'hFFFF_FFFF, QUAD_BOTTOM_RIGHT, i == 0);
        push_beat(32'd0, QUAD_TOP_RIGHT, 1'b0);
        push_beat(32'd2, QUAD_TOP_RIGHT, 1'b0);
        push_beat(32'd3, QUAD_TOP_RIGHT, 1'b0);
        push_beat(32'd5, QUAD_TOP_RIGHT, 1'b0);
        // A tile start in the middle of a tile restarts it.
        push_beat(random_sample(), QUAD_BOTTOM_LEFT, 1'b1);
        push_beat(random_sample(), QUAD_BOTTOM_LEFT, 1'b0);
        for (int i = 0; i < 4; i++) push_beat(random_sample(), QUAD_BOTTOM_LEFT, i == 0);
        drain_results();

        // Two samples per pixel (upper data bits ignored), left mid-tile; then the count
        // shrinks under it, so the next beat restarts the tile without a tile start.
        write_register(tpd_pkg::CFG_SAMPLES, 10'h3F2);
        settings_used++;
        for (int i = 0; i < 3; i++) push_beat(random_sample(), QUAD_TOP_LEFT, i == 0);
        drain_results();
        write_register(tpd_pkg::CFG_SAMPLES, 10'h000);
        write_register(tpd_pkg::CFG_LINEAR_MODE, 10'h3FE);
        write_register(tpd_pkg::CFG_TILE_SIDE, 10'd3);
        settings_used++;
        for (int i = 0; i < 4; i++) push_beat(random_sample(), QUAD_TOP_LEFT, 1'b0);
        drain_results();

        // Back pressure: the receiver holds off while the sender keeps offering.
        holds_requested++;
        rx_mode = RX_FREE;
        sender_steady = 1'b1;
        run_phase(10'd1, 10'd4, 10'd1, 96);

        // Random settings, mostly small tiles, with odd and out-of-range register values.
        while (random_queued < RANDOM_BEATS) begin
            case ($urandom_range(0, 9))
                0: side_word = 10'd0;
                1: side_word = 10'd1;
                2: side_word = 10'($urandom_range(2, 17));
                3: side_word = 10'($urandom_range(18, 40));
                default: side_word = 10'(2 * $urandom_range(1, 4));
            endcase
            spp_word = 10'($urandom_range(0, 1023));
            if (eff_side_of(side_word) > 16) spp_word[3:0] = 4'($urandom_range(0, 2));
            linear_word = 10'($urandom_range(0, 1023));
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            sender_steady = ($urandom_range(0, 3) == 0);
            run_phase(linear_word, side_word, spp_word, $urandom_range(40, 140));
        end

        // Largest side (from an over-range value), then most samples per pixel.
        rx_mode = RX_RANDOM;
        sender_steady = 1'b0;
        run_phase(10'($urandom_range(0, 1023)), 10'h3FF, 10'h3F1, 1);
        run_phase(10'd0, 10'd4, 10'd8, 1);

        $display("Covered %0d sample beats and %0d reduced samples over %0d register settings.",
                 beats_accepted, reductions_checked, settings_used);
        $display("Averaging and top-left modes, sides 2 to 512, 1 to 8 samples per pixel.");
        if (mismatches == 0) begin
            $display("tile_pyramid_2x2_downscale_top_tb: clean");
        end else begin
            $display("tile_pyramid_2x2_downscale_top_tb: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("tile_pyramid_2x2_downscale_top_tb: errors");
        $finish;
    end

endmodule

/* tile_pyramid_2x2_downscale_top.f */
+incdir+sv
sv/tpd_pkg.sv
sv/tpd_pair_mem.sv
sv/tpd_seq.sv
sv/tpd_reduce.sv
sv/tpd_out_buf.sv
sv/tile_pyramid_2x2_downscale_top.sv
sv/tpd_port_checker.sv
test/tile_pyramid_2x2_downscale_top_tb.sv
